/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/rvom_pkg.sv */
// Package for the voxel occupancy marker: types, register indexes, reset values.
// No dependencies.
`default_nettype none
package rvom_pkg;
  localparam int GridSideDefault = 64;
  localparam int CountW = 19;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] REG_ROT0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TY = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TZ = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INV = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_GEOM = 3'd7;

  localparam logic [47:0] RotRow0Rst = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Rst = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Rst = 48'h4000_0000_0000;
  localparam logic [31:0] InvRst = 32'h0001_0000;
  localparam logic [47:0] GeomRst = 48'h4040_4020_2020;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_SCALE, ST_READ, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic mul_step;
    logic scl_step;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mul_done;
    logic scl_done;
  } sts_t;
endpackage
`default_nettype wire

/* sv/rvom_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rvom_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/rvom_ctrl.sv */
// Controller state machine of the voxel occupancy marker.
// Depends on rvom_pkg.
`default_nettype none
module rvom_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire rvom_pkg::sts_t sts,
  output logic                in_rdy,
  output rvom_pkg::cmd_t      cmd
);
  rvom_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvom_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_rdy = 1'b0;
    unique case (state)
      rvom_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = rvom_pkg::ST_IDLE;
      end
      rvom_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = rvom_pkg::ST_MUL;
        end
      end
      rvom_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_next = rvom_pkg::ST_SCALE;
      end
      rvom_pkg::ST_SCALE: begin
        cmd.scl_step = 1'b1;
        if (sts.scl_done) state_next = rvom_pkg::ST_READ;
      end
      rvom_pkg::ST_READ: begin
        // RAM read latency
        state_next = rvom_pkg::ST_WRITE;
      end
      rvom_pkg::ST_WRITE: begin
        cmd.wr = 1'b1;
        state_next = rvom_pkg::ST_OUT;
      end
      rvom_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = rvom_pkg::ST_IDLE;
        end
      end
      default: state_next = rvom_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* sv/rvom_dp.sv */
// Datapath: translation, shared 16x33 multiplier, scale unit, occupancy store.
// Depends on rvom_pkg and rvom_ram.
`default_nettype none
module rvom_dp #(
  parameter int GridSide = rvom_pkg::GridSideDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rvom_pkg::cmd_t                  cmd,
  output rvom_pkg::sts_t                       sts,
  input  wire logic [95:0]                     in_data,
  input  wire logic                            cfg_we,
  input  wire logic [rvom_pkg::CfgIdxW-1:0]    cfg_idx,
  input  wire logic [rvom_pkg::CfgDataW-1:0]   cfg_data,
  output logic [6:0]                           res_x,
  output logic [6:0]                           res_y,
  output logic [6:0]                           res_z,
  output logic                                 res_in,
  output logic                                 res_new,
  output logic [rvom_pkg::CountW-1:0]          res_count
);
  localparam int SideW = $clog2(GridSide);
  localparam int AddrW = 3 * SideW;
  localparam int Cells = 1 << AddrW;

  logic [47:0] rot [3];
  logic signed [31:0] trans [3];
  logic [31:0] inv;
  logic [47:0] geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= rvom_pkg::RotRow0Rst;
      rot[1] <= rvom_pkg::RotRow1Rst;
      rot[2] <= rvom_pkg::RotRow2Rst;
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
      inv <= rvom_pkg::InvRst;
      geom <= rvom_pkg::GeomRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rvom_pkg::REG_ROT0: rot[0] <= cfg_data;
        rvom_pkg::REG_ROT1: rot[1] <= cfg_data;
        rvom_pkg::REG_ROT2: rot[2] <= cfg_data;
        rvom_pkg::REG_TX:   trans[0] <= cfg_data[31:0];
        rvom_pkg::REG_TY:   trans[1] <= cfg_data[31:0];
        rvom_pkg::REG_TZ:   trans[2] <= cfg_data[31:0];
        rvom_pkg::REG_INV:  inv <= cfg_data[31:0];
        rvom_pkg::REG_GEOM: geom <= cfg_data;
        default: ;
      endcase
    end
  end

  // Differences, exact at 33 bits.
  logic signed [32:0] d [3];
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < 3; c++) begin
        d[c] <= 33'(signed'(in_data[32*c +: 32])) - 33'(trans[c]);
      end
    end
  end

  // Rotation: one 16x33 product per cycle, nine steps, accumulate per row.
  logic [1:0] mr, mc;
  logic signed [48:0] prod;
  logic prod_v;
  logic signed [51:0] acc [3];
  logic [1:0] pr;
  logic signed [15:0] coef;
  logic signed [32:0] dsel;
  assign coef = signed'(rot[mr][16*mc +: 16]);
  assign dsel = d[mc];

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      mr <= '0;
      mc <= '0;
      prod_v <= 1'b0;
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end else if (cmd.mul_step) begin
      prod <= 49'(coef) * 49'(dsel);
      pr <= mr;
      prod_v <= !(mr == 2'd3);
      if (prod_v) acc[pr] <= acc[pr] + 52'(prod);
      if (mr != 2'd3) begin
        if (mc == 2'd2) begin
          mc <= '0;
          mr <= mr + 2'd1;
        end else begin
          mc <= mc + 2'd1;
        end
      end
    end
  end
  assign sts.mul_done = (mr == 2'd3) && !prod_v;

  // Scale: per axis, low half product then high half product.
  logic [1:0] sa;
  logic sph;
  logic [50:0] mag;
  logic neg;
  logic [63:0] lo_p;
  logic [63:0] hi_p;
  logic signed [53:0] idx [3];
  logic [1:0] sph2;
  logic [50:0] acc_mag;
  logic [31:0] mhalf;
  logic [63:0] mprod;
  logic [63:0] xsum;
  logic signed [53:0] qs;
  always_comb begin
    acc_mag = acc[sa][51] ? 51'(-acc[sa]) : 51'(acc[sa]);
    mhalf = sph ? {13'd0, mag[50:32]} : mag[31:0];
    mprod = 64'(mhalf) * 64'(inv);
    xsum = hi_p + {32'd0, lo_p[63:32]};
    qs = neg ? -54'(xsum[63:14]) : 54'(xsum[63:14]);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sa <= '0;
      sph <= 1'b0;
      sph2 <= '0;
    end else if (cmd.scl_step) begin
      // sph2: 0 latch mag, 1 low product, 2 high product, 3 combine
      unique case (sph2)
        2'd0: begin
          mag <= acc_mag;
          neg <= acc[sa][51];
          sph <= 1'b0;
          sph2 <= 2'd1;
        end
        2'd1: begin
          lo_p <= mprod;
          sph <= 1'b1;
          sph2 <= 2'd2;
        end
        2'd2: begin
          hi_p <= mprod;
          sph2 <= 2'd3;
        end
        default: begin
          idx[sa] <= qs + 54'(geom[8*sa +: 8]);
          sph2 <= 2'd0;
          if (sa != 2'd3) sa <= sa + 2'd1;
        end
      endcase
    end
  end
  assign sts.scl_done = (sa == 2'd3);

  // Bounds and occupancy.
  logic in_grid;
  logic [7:0] lim [3];
  always_comb begin
    in_grid = 1'b1;
    for (int r = 0; r < 3; r++) begin
      lim[r] = (geom[24+8*r +: 8] > 8'(GridSide)) ? 8'(GridSide) : geom[24+8*r +: 8];
      if (!(idx[r] > 0 && idx[r] < 54'(lim[r]))) in_grid = 1'b0;
    end
  end

  logic [AddrW-1:0] clr_addr;
  logic [AddrW:0] clr_cnt;
  logic [AddrW-1:0] vox_addr;
  logic [AddrW-1:0] ram_addr;
  logic ram_we, ram_wd, ram_rd;
  assign vox_addr = {idx[2][SideW-1:0], idx[1][SideW-1:0], idx[0][SideW-1:0]};
  assign clr_addr = clr_cnt[AddrW-1:0];
  assign sts.clr_done = clr_cnt[AddrW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step && !clr_cnt[AddrW]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic was_set;
  always_comb begin
    ram_addr = cmd.clr_step ? clr_addr : vox_addr;
    ram_we = cmd.clr_step || (cmd.wr && in_grid);
    ram_wd = !cmd.clr_step;
  end
  always_ff @(posedge clk) begin
    if (cmd.wr) was_set <= ram_rd;
  end

  rvom_ram #(.Width(1), .Depth(Cells)) u_occ (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic [rvom_pkg::CountW-1:0] count;
  logic inside_q;
  always_ff @(posedge clk) begin
    if (cmd.wr) inside_q <= in_grid;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.out_load && inside_q && !was_set && count != rvom_pkg::CountMax) begin
      count <= count + 1'b1;
    end
  end

  always_comb begin
    res_in = inside_q;
    res_new = inside_q && !was_set;
    res_x = inside_q ? idx[0][6:0] : '0;
    res_y = inside_q ? idx[1][6:0] : '0;
    res_z = inside_q ? idx[2][6:0] : '0;
    res_count = (res_new && count != rvom_pkg::CountMax) ? count + 1'b1 : count;
  end
endmodule
`default_nettype wire

/* sv/rigid_voxel_occupancy_marker.sv */
// Top level of the voxel occupancy marker.
// Depends on rvom_pkg, rvom_ctrl, rvom_dp.
//  channel  | dir | content
//  s_axis   | in  | tdata: point_x, point_y, point_z (96 bits)
//  m_axis   | out | tdata: voxel_x,y,z, in_bounds, newly_marked, new_count
//  cfg      | in  | wr_en, wr_idx, wr_data
// With no stall a point passes through acceptance, the nine passes of the shared 16x33
// multiplier, the twelve scale steps, one RAM read, one RAM write and the load of the
// output register.
// After reset a clearing pass writes zero to all 2^(3*clog2(GRID_SIDE)) cells before
// s_tready rises.
// A finished result waits in the output register; a stall holds the controller.
`default_nettype none
module rigid_voxel_occupancy_marker #(
  parameter int GRID_SIDE = rvom_pkg::GridSideDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // point_x, point_y, point_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // voxel_x, voxel_y, voxel_z, in_bounds, newly_marked, new_count
  input  wire logic        wr_en,
  input  wire logic [rvom_pkg::CfgIdxW-1:0]  wr_idx,
  input  wire logic [rvom_pkg::CfgDataW-1:0] wr_data
);
  rvom_pkg::cmd_t cmd;
  rvom_pkg::sts_t sts;
  logic [6:0] rx, ry, rz;
  logic ri, rn;
  logic [rvom_pkg::CountW-1:0] rc;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  rvom_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready), .out_free(out_free),
    .sts(sts), .in_rdy(s_tready), .cmd(cmd)
  );

  rvom_dp #(.GridSide(GRID_SIDE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_data(s_tdata),
    .cfg_we(wr_en), .cfg_idx(wr_idx), .cfg_data(wr_data),
    .res_x(rx), .res_y(ry), .res_z(rz), .res_in(ri), .res_new(rn), .res_count(rc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'd0, rc, rn, ri, rz, ry, rx};
    end
  end
endmodule
`default_nettype wire

/* sv/rvom_chk.sv */
// Port checker for the voxel occupancy marker, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rvom_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);
  `CHK_IMPL(a_new_in, clk, rst, m_tvalid && m_tdata[22], m_tdata[21], "new voxel not in bounds")
  `CHK_IMPL(a_oob_zero, clk, rst, m_tvalid && !m_tdata[21], m_tdata[20:0] == 21'd0, "oob voxel nonzero")
  `CHK_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "took second point")
  `CHK_IMPL(a_hold, clk, rst, $past(m_tvalid && !m_tready) && !$past(rst), m_tvalid && $stable(m_tdata), "result dropped")
endmodule
bind rigid_voxel_occupancy_marker rvom_chk u_chk (.*);
`default_nettype wire

/* tb/sv/rigid_voxel_occupancy_marker_test.sv */
// Testbench for rigid_voxel_occupancy_marker: streams points, predicts each voxel
// result and the occupancy state internally, and checks every output transaction.
// Depends on rvom_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module rigid_voxel_occupancy_marker_test;
  localparam int Side = rvom_pkg::GridSideDefault;
  localparam int Cells = Side * Side * Side;
  localparam longint CycleLimit = 6000000;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  typedef struct {
    logic [6:0]  vx;
    logic [6:0]  vy;
    logic [6:0]  vz;
    logic        inb;
    logic        fresh;
    logic [18:0] cnt;
  } voxel_res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;
  logic wr_en = 0;
  logic [rvom_pkg::CfgIdxW-1:0] wr_idx = rvom_pkg::REG_ROT0;
  logic [rvom_pkg::CfgDataW-1:0] wr_data = '0;

  rigid_voxel_occupancy_marker u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
  );

  // predictor state
  logic [47:0] rot [3];
  logic signed [31:0] trans [3];
  logic [31:0] inv_size;
  logic [47:0] geom;
  bit occ [Cells];
  logic [18:0] marked;

  point_t pending_points [$];
  voxel_res_t expected_voxels [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  bit taken = 0;
  bit failed = 0;
  longint cycles = 0;

  initial forever #6 clk = ~clk;

  function automatic voxel_res_t predict_voxel(point_t p);
    voxel_res_t res;
    longint d [3];
    longint idx [3];
    longint s, center, size, q;
    logic [63:0] m;
    logic [95:0] prod;
    bit in_grid;
    int slot;
    d[0] = longint'(signed'(p.x)) - longint'(trans[0]);
    d[1] = longint'(signed'(p.y)) - longint'(trans[1]);
    d[2] = longint'(signed'(p.z)) - longint'(trans[2]);
    in_grid = 1;
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++)
        s += longint'(signed'(rot[r][16*c +: 16])) * d[c];
      m = (s < 0) ? -s : s;
      prod = {32'b0, m} * {64'b0, inv_size};
      q = longint'(prod >> 46);
      center = longint'(geom[8*r +: 8]);
      size = longint'(geom[24 + 8*r +: 8]);
      if (size > Side) size = Side;
      idx[r] = ((s < 0) ? -q : q) + center;
      if (!(idx[r] > 0 && idx[r] < size)) in_grid = 0;
    end
    res.fresh = 0;
    if (in_grid) begin
      slot = int'(idx[0] + Side * (idx[1] + Side * idx[2]));
      if (!occ[slot]) begin
        occ[slot] = 1;
        res.fresh = 1;
        if (marked != rvom_pkg::CountMax) marked++;
      end
    end
    res.vx = in_grid ? idx[0][6:0] : '0;
    res.vy = in_grid ? idx[1][6:0] : '0;
    res.vz = in_grid ? idx[2][6:0] : '0;
    res.inb = in_grid;
    res.cnt = marked;
    return res;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      failed = 1;
    end
  endfunction

  // input transactions and output checking
  always @(posedge clk) begin
    voxel_res_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      expected_voxels.push_back(predict_voxel(point_t'(s_tdata)));
      taken <= 1;
    end else begin
      taken <= 0;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_voxels.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        failed = 1;
      end else begin
        e = expected_voxels.pop_front();
        check_field("voxel_x", e.vx, m_tdata[6:0]);
        check_field("voxel_y", e.vy, m_tdata[13:7]);
        check_field("voxel_z", e.vz, m_tdata[20:14]);
        check_field("in_bounds", e.inb, m_tdata[21]);
        check_field("newly_marked", e.fresh, m_tdata[22]);
        check_field("new_count", e.cnt, m_tdata[41:23]);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !taken)) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= pending_points.pop_front();
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_idle();
    while (pending_points.size() > 0 || s_tvalid || expected_voxels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [rvom_pkg::CfgIdxW-1:0] idx,
                           logic [rvom_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    wr_en <= 1;
    wr_idx <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
    case (idx)
      rvom_pkg::REG_ROT0: rot[0] = val;
      rvom_pkg::REG_ROT1: rot[1] = val;
      rvom_pkg::REG_ROT2: rot[2] = val;
      rvom_pkg::REG_TX: trans[0] = val[31:0];
      rvom_pkg::REG_TY: trans[1] = val[31:0];
      rvom_pkg::REG_TZ: trans[2] = val[31:0];
      rvom_pkg::REG_INV: inv_size = val[31:0];
      rvom_pkg::REG_GEOM: geom = val;
      default: ;
    endcase
  endtask

  task automatic set_pose(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                          logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                          logic [31:0] inv, logic [47:0] g);
    write_reg(rvom_pkg::REG_ROT0, r0);
    write_reg(rvom_pkg::REG_ROT1, r1);
    write_reg(rvom_pkg::REG_ROT2, r2);
    write_reg(rvom_pkg::REG_TX, tx);
    write_reg(rvom_pkg::REG_TY, ty);
    write_reg(rvom_pkg::REG_TZ, tz);
    write_reg(rvom_pkg::REG_INV, inv);
    write_reg(rvom_pkg::REG_GEOM, g);
  endtask

  // near points cover +-span around the translation, others are any 32-bit value
  function automatic logic [31:0] coord(int span, int near_pct, logic [31:0] base);
    if ($urandom_range(99) < near_pct)
      return base + 32'($urandom_range(2 * span)) - 32'(span);
    return $urandom;
  endfunction

  task automatic send_random(int n, int span);
    point_t p;
    repeat (n) begin
      p.x = coord(span, 85, trans[0]);
      p.y = coord(span, 85, trans[1]);
      p.z = coord(span, 85, trans[2]);
      pending_points.push_back(p);
    end
  endtask

  task automatic send_point(int x, int y, int z);
    pending_points.push_back({32'(z), 32'(y), 32'(x)});
  endtask

  initial begin
    rot[0] = rvom_pkg::RotRow0Rst;
    rot[1] = rvom_pkg::RotRow1Rst;
    rot[2] = rvom_pkg::RotRow2Rst;
    trans[0] = 0;
    trans[1] = 0;
    trans[2] = 0;
    inv_size = rvom_pkg::InvRst;
    geom = rvom_pkg::GeomRst;
    marked = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed, reset pose: edges of the grid, truncation, repeats, field extremes
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_point(-32 << 16, 0, 0);
    send_point(-31 << 16, 0, 0);
    send_point(31 << 16, 0, 0);
    send_point(32 << 16, 0, 0);
    send_point(0, -31 << 16, 31 << 16);
    send_point(0, 32 << 16, 0);
    send_point(0, 0, -32 << 16);
    send_point(-32768, -65535, 65535);
    send_point((31 << 16) + 65535, 5 << 16, -(31 << 16) - 65535);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h7fffffff, 0, 32'h80000000);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
    wait_idle();

    // grid sizes above the side are clipped; scale 2.0, offset pose
    set_pose(rvom_pkg::RotRow0Rst, rvom_pkg::RotRow1Rst, rvom_pkg::RotRow2Rst,
             32'h0003_8000, 32'hfffe_0000, 32'h0000_4000, 32'h0002_0000,
             48'hff_ff_ff_20_20_20);
    send_point(32'h0003_8000 + (16 << 16), 0, 0);
    send_point(32'h0003_8000 + (15 << 16), 32'hfffe_0000, 32'h0000_4000);
    for (int blk = 0; blk < 8; blk++) begin
      if (blk == 2)
        // rotation about z, negative column entries, half scale, centers of 32, 20 and 24
        set_pose(48'h0000_c000_0000, 48'h0000_0000_4000, rvom_pkg::RotRow2Rst,
                 32'hfff0_0000, 32'h0010_0000, 32'h0000_0000, 32'h0000_8000,
                 48'h30_28_40_18_14_20);
      else if (blk == 4)
        // zero scale maps every point to the center voxel
        set_pose(48'h1234_5678_9abc, 48'hffff_ffff_ffff, 48'h8000_7fff_0001,
                 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 48'h0a_0a_0a_05_06_07);
      else if (blk == 5)
        // all extremes, then mild skew with fine scale
        set_pose(48'hffff_ffff_ffff, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
                 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'hffffffff,
                 48'hffff_ffff_ffff);
      else if (blk == 6)
        set_pose(48'h0000_0400_3c00, 48'h0000_4000_fc00, 48'h4000_0200_0000,
                 32'h0012_3456, 32'hffed_cba9, 32'h0001_0000, 32'h0004_0000,
                 48'h40_3c_38_1e_20_1c);
      send_idle_pct = (blk % 4 == 1 || blk % 4 == 3) ? 60 : 0;
      stall_pct = (blk % 4 == 2) ? 60 : 0;
      if (blk % 4 == 3) begin
        send_idle_pct = 28;
        stall_pct = 28;
      end
      if (blk == 0) hold_cycles = 400;
      send_random(100, (blk == 4 || blk == 5) ? 32'h0008_0000 : 32'h0018_0000);
      // drain before each block that rewrites the pose; blocks 0 and 7 drain as well
      if (blk % 2 == 1 || blk == 0 || blk == 4) wait_idle();
    end
    wait_idle();
    repeat (60) @(posedge clk);
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/rvom_pkg.sv
sv/rvom_ram.sv
sv/rvom_ctrl.sv
sv/rvom_dp.sv
sv/rigid_voxel_occupancy_marker.sv
sv/rvom_chk.sv
tb/sv/rigid_voxel_occupancy_marker_test.sv
